@@ rtl/dll_pkg.sv @@
// shared types and constants for the dma block and linked-list sequencer
package dll_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_CONT  = 1'b1;

  localparam logic [2:0] CH_GPU = 3'd2;
  localparam logic [2:0] CH_OTC = 3'd6;

  localparam logic [31:0] ALIGN_MASK = 32'h001f_fffc;
  localparam logic [31:0] LAST_ENTRY = 32'h00ff_ffff;

  typedef enum logic [1:0] {
    RAM_NONE  = 2'd0,
    RAM_READ  = 2'd1,
    RAM_WRITE = 2'd2
  } ram_op_t;

  // transfer kind, one-hot
  typedef enum logic [3:0] {
    MODE_NONE  = 4'b0001,
    MODE_CLEAR = 4'b0010,
    MODE_BLOCK = 4'b0100,
    MODE_LIST  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  channel;
    logic [23:0] base_address;
    logic [19:0] word_count;
    logic        step_backward;
    logic        to_ram;
    logic        list_mode;
    logic [31:0] read_data;
  } req_t;

  typedef struct packed {
    ram_op_t     ram_op;
    logic [20:0] ram_address;
    logic [31:0] ram_write_data;
    logic        gpu_valid;
    logic [31:0] gpu_data;
    logic        done_res;
    logic        error;
  } res_t;

  // sequencer state; addresses kept as word indexes
  typedef struct packed {
    mode_t       mode;
    logic [18:0] cur_word;
    logic [19:0] words_left;
    logic        going_down;
    logic        in_payload;
    logic [7:0]  payload_left;
    logic [18:0] link_word;
    logic        end_flag;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:         MODE_NONE,
    cur_word:     19'd0,
    words_left:   20'd0,
    going_down:   1'b0,
    in_payload:   1'b0,
    payload_left: 8'd0,
    link_word:    19'd0,
    end_flag:     1'b0
  };

endpackage

@@ rtl/dll_step.sv @@
// next-state and result logic for one request
module dll_step #(
  parameter int unsigned RAM_BYTES = 2097152
) (
  input  dll_pkg::req_t   req,
  input  dll_pkg::state_t st,
  output dll_pkg::state_t st_nxt,
  output dll_pkg::res_t   res
);
  import dll_pkg::*;

  localparam int unsigned RAM_LIM   = RAM_BYTES - 1;
  localparam int unsigned MAX_WORDS = RAM_BYTES / 4;
  localparam logic [20:0] ADDR_MASK = 21'(RAM_LIM & ALIGN_MASK);
  localparam logic [31:0] WRAP_MASK = 32'(RAM_LIM);
  localparam logic [19:0] WORD_CAP  =
    (MAX_WORDS > 32'h000f_ffff) ? 20'hf_ffff : 20'(MAX_WORDS);

  function automatic logic [20:0] byte_addr(input logic [18:0] w);
    return {w, 2'b00} & ADDR_MASK;
  endfunction

  mode_t       new_mode;
  logic [19:0] cnt_sat;
  state_t      fresh;
  state_t      src;
  logic [18:0] step_word;
  logic [18:0] seq_word;
  logic [31:0] cur_byte;
  logic [31:0] clr_val;
  logic [19:0] clr_left;
  logic [7:0]  hdr_cnt;
  logic [7:0]  pay_left;

  always_comb begin
    priority if (req.list_mode) begin
      new_mode = (req.channel == CH_GPU && !req.to_ram) ? MODE_LIST : MODE_NONE;
    end else if (req.to_ram) begin
      new_mode = (req.channel == CH_OTC) ? MODE_CLEAR : MODE_NONE;
    end else begin
      new_mode = (req.channel == CH_GPU) ? MODE_BLOCK : MODE_NONE;
    end
  end

  assign cnt_sat = (req.word_count > WORD_CAP) ? WORD_CAP : req.word_count;

  always_comb begin
    fresh              = st;
    fresh.mode         = new_mode;
    fresh.cur_word     = req.base_address[20:2];
    fresh.going_down   = req.step_backward;
    fresh.words_left   = cnt_sat;
    fresh.in_payload   = 1'b0;
    fresh.payload_left = 8'd0;
    fresh.link_word    = 19'd0;
    fresh.end_flag     = 1'b0;
  end

  assign src       = (req.opcode == OP_START) ? fresh : st;
  assign step_word = src.going_down ? src.cur_word - 19'd1 : src.cur_word + 19'd1;
  assign seq_word  = st.cur_word + 19'd1;
  assign cur_byte  = {11'd0, src.cur_word, 2'b00};
  assign clr_val   = (src.words_left == 20'd1) ? LAST_ENTRY
                   : ((cur_byte - 32'd4) & WRAP_MASK);
  assign clr_left  = src.words_left - 20'd1;
  assign hdr_cnt   = req.read_data[31:24];
  assign pay_left  = st.payload_left - 8'd1;

  always_comb begin
    st_nxt = st;
    res    = '0;
    res.ram_op = RAM_NONE;
    if (req.opcode == OP_START) begin
      st_nxt = fresh;
      priority if (new_mode == MODE_NONE) begin
        st_nxt      = st;
        st_nxt.mode = MODE_NONE;
        res.error   = 1'b1;
      end else if (new_mode == MODE_LIST) begin
        res.ram_op      = RAM_READ;
        res.ram_address = byte_addr(fresh.cur_word);
      end else if (cnt_sat == 20'd0) begin
        st_nxt.mode  = MODE_NONE;
        res.done_res = 1'b1;
      end else if (new_mode == MODE_CLEAR) begin
        res.ram_op         = RAM_WRITE;
        res.ram_address    = byte_addr(src.cur_word);
        res.ram_write_data = clr_val;
        st_nxt.cur_word    = step_word;
        st_nxt.words_left  = clr_left;
        if (clr_left == 20'd0) begin
          st_nxt.mode  = MODE_NONE;
          res.done_res = 1'b1;
        end
      end else begin
        res.ram_op      = RAM_READ;
        res.ram_address = byte_addr(fresh.cur_word);
      end
    end else begin
      unique case (st.mode)
        MODE_NONE: begin
        end
        MODE_CLEAR: begin
          res.ram_op         = RAM_WRITE;
          res.ram_address    = byte_addr(src.cur_word);
          res.ram_write_data = clr_val;
          st_nxt.cur_word    = step_word;
          st_nxt.words_left  = clr_left;
          if (clr_left == 20'd0) begin
            st_nxt.mode  = MODE_NONE;
            res.done_res = 1'b1;
          end
        end
        MODE_BLOCK: begin
          res.gpu_valid     = 1'b1;
          res.gpu_data      = req.read_data;
          st_nxt.cur_word   = step_word;
          st_nxt.words_left = clr_left;
          if (clr_left == 20'd0) begin
            st_nxt.mode  = MODE_NONE;
            res.done_res = 1'b1;
          end else begin
            res.ram_op      = RAM_READ;
            res.ram_address = byte_addr(step_word);
          end
        end
        MODE_LIST: begin
          if (!st.in_payload) begin
            // header word
            st_nxt.link_word    = req.read_data[20:2];
            st_nxt.end_flag     = req.read_data[23];
            st_nxt.payload_left = hdr_cnt;
            if (hdr_cnt != 8'd0) begin
              st_nxt.in_payload = 1'b1;
              st_nxt.cur_word   = seq_word;
              res.ram_op        = RAM_READ;
              res.ram_address   = byte_addr(seq_word);
            end else if (req.read_data[23]) begin
              st_nxt.mode  = MODE_NONE;
              res.done_res = 1'b1;
            end else begin
              st_nxt.cur_word = req.read_data[20:2];
              res.ram_op      = RAM_READ;
              res.ram_address = byte_addr(req.read_data[20:2]);
            end
          end else begin
            // payload word
            res.gpu_valid       = 1'b1;
            res.gpu_data        = req.read_data;
            st_nxt.payload_left = pay_left;
            if (pay_left != 8'd0) begin
              st_nxt.cur_word = seq_word;
              res.ram_op      = RAM_READ;
              res.ram_address = byte_addr(seq_word);
            end else begin
              st_nxt.in_payload = 1'b0;
              if (st.end_flag) begin
                st_nxt.mode  = MODE_NONE;
                res.done_res = 1'b1;
              end else begin
                st_nxt.cur_word = st.link_word;
                res.ram_op      = RAM_READ;
                res.ram_address = byte_addr(st.link_word);
              end
            end
          end
        end
        default: begin
          st_nxt.mode = MODE_NONE;
        end
      endcase
    end
  end

endmodule

@@ rtl/dma_block_and_linked_list_engine.sv @@
// top level of the dma block and linked-list sequencer
//
//  channel | direction | ports                        | handshake
//  --------+-----------+------------------------------+----------------------
//  in      | to block  | in_opcode .. in_read_data    | in_valid / in_stall
//  out     | from block| out_ram_op .. out_error      | out_valid / out_stall
//
// one request per cycle sustained while out_stall stays low; every request gives exactly one result
// a request passes through the request register, then the step logic, then the result register
// the sequencer state advances as a request moves from the request register
// into the result register, so back-to-back requests see each other's effects
// reset (rst_n low, synchronous) empties both registers and idles the sequencer
// a stalled result holds; the request register fills behind it, then in_stall rises
module dma_block_and_linked_list_engine #(
  parameter int unsigned RAM_BYTES = 2097152
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [2:0]  in_channel,
  input  logic [23:0] in_base_address,
  input  logic [19:0] in_word_count,
  input  logic        in_step_backward,
  input  logic        in_to_ram,
  input  logic        in_list_mode,
  input  logic [31:0] in_read_data,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_ram_op,
  output logic [20:0] out_ram_address,
  output logic [31:0] out_ram_write_data,
  output logic        out_gpu_valid,
  output logic [31:0] out_gpu_data,
  output logic        out_done_res,
  output logic        out_error
);
  import dll_pkg::*;

  // request register
  logic   req_vld_r;
  logic   req_vld_nxt;
  req_t   req_r;

  // result register
  logic   res_vld_r;
  logic   res_vld_nxt;
  res_t   res_r;

  // sequencer state
  state_t st_r;
  state_t st_nxt;
  res_t   res_nxt;

  logic   res_free;   // result register can take a new value
  logic   fire;       // request moves into the result register
  logic   in_take;

  assign res_free = !res_vld_r || !out_stall;
  assign fire     = req_vld_r && res_free;
  assign in_stall = req_vld_r && !res_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    priority if (in_take) begin
      req_vld_nxt = 1'b1;
    end else if (fire) begin
      req_vld_nxt = 1'b0;
    end else begin
      req_vld_nxt = req_vld_r;
    end
  end

  always_comb begin
    priority if (fire) begin
      res_vld_nxt = 1'b1;
    end else if (res_free) begin
      res_vld_nxt = 1'b0;
    end else begin
      res_vld_nxt = res_vld_r;
    end
  end

  dll_step #(
    .RAM_BYTES (RAM_BYTES)
  ) u_step (
    .req    (req_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      st_r      <= STATE_RESET;
    end else begin
      req_vld_r <= req_vld_nxt;
      res_vld_r <= res_vld_nxt;
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.opcode        <= in_opcode;
      req_r.channel       <= in_channel;
      req_r.base_address  <= in_base_address;
      req_r.word_count    <= in_word_count;
      req_r.step_backward <= in_step_backward;
      req_r.to_ram        <= in_to_ram;
      req_r.list_mode     <= in_list_mode;
      req_r.read_data     <= in_read_data;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = res_vld_r;
  assign out_ram_op         = res_r.ram_op;
  assign out_ram_address    = res_r.ram_address;
  assign out_ram_write_data = res_r.ram_write_data;
  assign out_gpu_valid      = res_r.gpu_valid;
  assign out_gpu_data       = res_r.gpu_data;
  assign out_done_res       = res_r.done_res;
  assign out_error          = res_r.error;

endmodule

@@ test/dll_scoreboard_pkg.sv @@
// scoreboard class: predicts each result of the dma sequencer and checks the results that come out
`timescale 1ns / 1ps
package dll_scoreboard_pkg;
  import dll_pkg::*;

  localparam int unsigned SIM_RAM_BYTES = 2097152;
  localparam logic [31:0] RAM_MASK = SIM_RAM_BYTES - 1;

  class dma_scoreboard;
    mode_t       xfer_mode;
    logic [20:0] addr;
    logic [19:0] remaining;
    bit          downward;
    bit          mid_packet;
    logic [7:0]  packet_left;
    logic [31:0] header;
    res_t        nxt;
    res_t        expected_q[$];
    int          errors;

    function new();
      xfer_mode   = MODE_NONE;
      addr        = '0;
      remaining   = '0;
      downward    = 1'b0;
      mid_packet  = 1'b0;
      packet_left = '0;
      header      = '0;
      errors      = 0;
    endfunction

    function logic [20:0] ram_addr(logic [20:0] a);
      return a & RAM_MASK[20:0] & ALIGN_MASK[20:0];
    endfunction

    function void step_address();
      if (downward) addr = (addr - 21'd4) & ALIGN_MASK[20:0];
      else addr = (addr + 21'd4) & ALIGN_MASK[20:0];
    endfunction

    function void end_transfer();
      xfer_mode = MODE_NONE;
      nxt.done_res = 1'b1;
    endfunction

    function void issue_read();
      nxt.ram_op = RAM_READ;
      nxt.ram_address = ram_addr(addr);
    endfunction

    function void write_table_entry();
      nxt.ram_op = RAM_WRITE;
      nxt.ram_address = ram_addr(addr);
      nxt.ram_write_data = (remaining == 20'd1) ? LAST_ENTRY
                           : ((32'(addr) - 32'd4) & RAM_MASK);
      step_address();
      remaining = remaining - 20'd1;
      if (remaining == 20'd0) end_transfer();
    endfunction

    // packet done: stop on the end flag, else follow the link
    function void next_packet();
      mid_packet = 1'b0;
      if (header[23]) begin
        end_transfer();
      end else begin
        addr = header[20:0] & ALIGN_MASK[20:0];
        issue_read();
      end
    endfunction

    function void note_request(req_t r);
      mode_t       kind;
      logic [31:0] cnt;
      nxt = '0;
      if (r.opcode == OP_START) begin
        xfer_mode = MODE_NONE;
        if (r.list_mode) kind = (r.channel == CH_GPU && !r.to_ram) ? MODE_LIST : MODE_NONE;
        else if (r.to_ram) kind = (r.channel == CH_OTC) ? MODE_CLEAR : MODE_NONE;
        else kind = (r.channel == CH_GPU) ? MODE_BLOCK : MODE_NONE;
        if (kind == MODE_NONE) begin
          nxt.error = 1'b1;
        end else begin
          cnt = 32'(r.word_count);
          if (cnt > SIM_RAM_BYTES / 4) cnt = SIM_RAM_BYTES / 4;
          addr        = r.base_address[20:0] & ALIGN_MASK[20:0];
          downward    = r.step_backward;
          remaining   = cnt[19:0];
          mid_packet  = 1'b0;
          packet_left = '0;
          header      = '0;
          xfer_mode   = kind;
          if (kind == MODE_LIST) issue_read();
          else if (remaining == 20'd0) end_transfer();
          else if (kind == MODE_CLEAR) write_table_entry();
          else issue_read();
        end
      end else begin
        case (xfer_mode)
          MODE_CLEAR: write_table_entry();
          MODE_BLOCK: begin
            nxt.gpu_valid = 1'b1;
            nxt.gpu_data = r.read_data;
            step_address();
            remaining = remaining - 20'd1;
            if (remaining == 20'd0) end_transfer();
            else issue_read();
          end
          MODE_LIST: begin
            if (!mid_packet) begin
              header = r.read_data;
              packet_left = r.read_data[31:24];
              if (packet_left != 8'd0) begin
                mid_packet = 1'b1;
                addr = (addr + 21'd4) & ALIGN_MASK[20:0];
                issue_read();
              end else begin
                next_packet();
              end
            end else begin
              nxt.gpu_valid = 1'b1;
              nxt.gpu_data = r.read_data;
              packet_left = packet_left - 8'd1;
              if (packet_left != 8'd0) begin
                addr = (addr + 21'd4) & ALIGN_MASK[20:0];
                issue_read();
              end else begin
                next_packet();
              end
            end
          end
          default: ;
        endcase
      end
      expected_q.push_back(nxt);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, expected nothing, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare("ram_op", 32'(want.ram_op), 32'(got.ram_op));
      compare("ram_address", 32'(want.ram_address), 32'(got.ram_address));
      compare("ram_write_data", want.ram_write_data, got.ram_write_data);
      compare("gpu_valid", 32'(want.gpu_valid), 32'(got.gpu_valid));
      compare("gpu_data", want.gpu_data, got.gpu_data);
      compare("done_res", 32'(want.done_res), 32'(got.done_res));
      compare("error", 32'(want.error), 32'(got.error));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ test/testbench.sv @@
// top-level testbench for the dma block and linked-list sequencer
`timescale 1ns / 1ps
module testbench;
  import dll_pkg::*;
  import dll_scoreboard_pkg::*;

  // run shape
  localparam int N_ITEMS        = 1950;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [2:0]  in_channel;
  logic [23:0] in_base_address;
  logic [19:0] in_word_count;
  logic        in_step_backward;
  logic        in_to_ram;
  logic        in_list_mode;
  logic [31:0] in_read_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_ram_op;
  logic [20:0] out_ram_address;
  logic [31:0] out_ram_write_data;
  logic        out_gpu_valid;
  logic [31:0] out_gpu_data;
  logic        out_done_res;
  logic        out_error;

  dma_scoreboard sb;

  // idling switches, changed per transfer in the random part
  bit tx_idle;
  bit rx_idle;
  // asks the result side for one long hold-off
  bit hold_req;
  // requests that did real work, continues on an idle sequencer left out
  int sent;
  int quiet;

  dma_block_and_linked_list_engine #(.RAM_BYTES(SIM_RAM_BYTES)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_channel         (in_channel),
    .in_base_address    (in_base_address),
    .in_word_count      (in_word_count),
    .in_step_backward   (in_step_backward),
    .in_to_ram          (in_to_ram),
    .in_list_mode       (in_list_mode),
    .in_read_data       (in_read_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ram_op         (out_ram_op),
    .out_ram_address    (out_ram_address),
    .out_ram_write_data (out_ram_write_data),
    .out_gpu_valid      (out_gpu_valid),
    .out_gpu_data       (out_gpu_data),
    .out_done_res       (out_done_res),
    .out_error          (out_error)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // one request: optional gap, then hold it until taken
  // entered and left at a falling edge, so valid is written once per step
  task automatic send_item(input req_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= r.opcode;
    in_channel       <= r.channel;
    in_base_address  <= r.base_address;
    in_word_count    <= r.word_count;
    in_step_backward <= r.step_backward;
    in_to_ram        <= r.to_ram;
    in_list_mode     <= r.list_mode;
    in_read_data     <= r.read_data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.opcode == OP_START || sb.xfer_mode != MODE_NONE) sent++;
    sb.note_request(r);
    @(negedge clk);
  endtask

  // start request; read_data is a don't-care here, so it gets noise
  task automatic send_start(input logic [2:0] ch, input logic [23:0] base,
                            input logic [19:0] cnt, input bit down, input bit toram,
                            input bit list);
    req_t r;
    r.opcode        = OP_START;
    r.channel       = ch;
    r.base_address  = base;
    r.word_count    = cnt;
    r.step_backward = down;
    r.to_ram        = toram;
    r.list_mode     = list;
    r.read_data     = $urandom();
    send_item(r);
  endtask

  // continue request carrying the word the last read returned
  // the start-only fields get noise to show they are ignored
  task automatic send_cont(input logic [31:0] rd);
    req_t r;
    r.opcode        = OP_CONT;
    r.channel       = 3'($urandom());
    r.base_address  = 24'($urandom());
    r.word_count    = 20'($urandom());
    r.step_backward = 1'($urandom());
    r.to_ram        = 1'($urandom());
    r.list_mode     = 1'($urandom());
    r.read_data     = rd;
    send_item(r);
  endtask

  // list header: mostly short packets, sometimes a long one, end flag one time in three
  function automatic logic [31:0] list_header();
    logic [7:0] words;
    bit         last;
    words = ($urandom_range(0, 15) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
    last  = ($urandom_range(0, 2) == 0);
    return {words, last, 23'($urandom())};
  endfunction

  // word for the next continue: a header where the walk expects one, else data
  function automatic logic [31:0] read_word();
    if (sb.xfer_mode == MODE_LIST && !sb.mid_packet) return list_header();
    return $urandom();
  endfunction

  function automatic logic [19:0] short_count();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 20'd0;
    if (r == 1) return 20'($urandom_range(9, 64));
    return 20'($urandom_range(1, 8));
  endfunction

  // keep feeding continues while a transfer runs; a low cap leaves it to be
  // cut off by the next start
  task automatic follow(input int cap);
    int n;
    n = 0;
    while (sb.xfer_mode != MODE_NONE && n < cap) begin
      send_cont(read_word());
      n++;
    end
  endtask

  // result side: random stall per result, plus one long hold-off
  initial begin : result_side
    int   wait_left;
    int   hold_left;
    bit   hold_taken;
    res_t got;
    wait_left  = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.ram_op         = ram_op_t'(out_ram_op);
        got.ram_address    = out_ram_address;
        got.ram_write_data = out_ram_write_data;
        got.gpu_valid      = out_gpu_valid;
        got.gpu_data       = out_gpu_data;
        got.done_res       = out_done_res;
        got.error          = out_error;
        sb.check_result(got);
        wait_left = rx_idle ? $urandom_range(0, 3) : 0;
      end
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long with neither side moving means a hang
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int  pick;
    int  cap;
    bit  hold_asked;
    sb = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = OP_START;
    in_channel       = '0;
    in_base_address  = '0;
    in_word_count    = '0;
    in_step_backward = 1'b0;
    in_to_ram        = 1'b0;
    in_list_mode     = 1'b0;
    in_read_data     = '0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    hold_req         = 1'b0;
    hold_asked       = 1'b0;
    sent             = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    send_cont(32'hffff_ffff);                                 // continue with nothing running
    send_start(3'd0, 24'h00_0000, 20'd4, 1'b0, 1'b0, 1'b0);   // unknown channel
    send_start(CH_OTC, 24'h00_0000, 20'd4, 1'b0, 1'b0, 1'b0); // table clear not toward ram
    send_start(CH_GPU, 24'h00_0000, 20'd4, 1'b0, 1'b1, 1'b0); // gpu channel toward ram
    send_start(CH_OTC, 24'h00_0000, 20'd4, 1'b0, 1'b1, 1'b1); // list on the clear channel
    send_start(CH_GPU, 24'hff_ffff, 20'd0, 1'b0, 1'b0, 1'b0); // empty block
    // table clear walking down through address zero
    send_start(CH_OTC, 24'h00_0004, 20'd3, 1'b1, 1'b1, 1'b0);
    send_cont(32'h0);
    send_cont(32'h0);
    // block read climbing past the top of ram, upper base bits ignored
    send_start(CH_GPU, 24'hff_fffc, 20'd2, 1'b0, 1'b0, 1'b0);
    send_cont(32'hffff_ffff);
    send_cont(32'h0000_0000);
    // two-packet list: one word then an empty terminating header
    send_start(CH_GPU, 24'h00_0100, 20'd0, 1'b0, 1'b0, 1'b1);
    send_cont({8'd1, 1'b0, 23'h00_0200});
    send_cont(32'hdead_beef);
    send_cont({8'd0, 1'b1, 23'h7f_ffff});
    // count above ram size saturates, then a new start cuts it off
    send_start(CH_GPU, 24'h00_0000, 20'hf_ffff, 1'b1, 1'b0, 1'b0);
    send_cont(32'h1234_5678);
    send_start(CH_OTC, 24'h12_3456, 20'd2, 1'b0, 1'b1, 1'b0);
    send_cont(32'h0);

    // random part: mostly whole transfers with random content
    while (sent < N_ITEMS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      // a third of the way in, back-pressure hard while the sender keeps going
      if (!hold_asked && sent >= N_ITEMS / 3) begin
        hold_asked = 1'b1;
        hold_req   = 1'b1;
        tx_idle    = 1'b0;
      end
      cap  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 400;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // anything at all, mostly unsupported combinations
        send_start(3'($urandom()), 24'($urandom()), 20'($urandom_range(0, 8)),
                   1'($urandom()), 1'($urandom()), 1'($urandom()));
      end else if (pick == 1) begin
        send_cont($urandom());
      end else if (pick == 2) begin
        // huge count, always cut short
        send_start(($urandom_range(0, 1) != 0) ? CH_GPU : CH_OTC, 24'($urandom()),
                   20'($urandom()), 1'($urandom()), 1'b0, 1'b0);
        cap = $urandom_range(1, 6);
      end else if (pick < 8) begin
        send_start(CH_OTC, 24'($urandom()), short_count(), 1'($urandom()), 1'b1, 1'b0);
      end else if (pick < 14) begin
        send_start(CH_GPU, 24'($urandom()), short_count(), 1'($urandom()), 1'b0, 1'b0);
      end else begin
        send_start(CH_GPU, 24'($urandom()), 20'($urandom()), 1'($urandom()), 1'b0, 1'b1);
      end
      follow(cap);
    end
    in_valid <= 1'b0;

    // let every result come back, then a little longer for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
